@@ rtl/prme_pkg.sv @@
// Shared constants, codes and types of the predicated register machine.
package prme_pkg;

  localparam int unsigned NUM_REGS  = 4;
  localparam int unsigned FIRST_REG = 5;
  localparam int unsigned IDX_W     = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int unsigned DATA_W    = 8;

  localparam logic [8:0] REG_LO = 9'(FIRST_REG);
  localparam logic [8:0] REG_HI = 9'(FIRST_REG + NUM_REGS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_REGS - 1);

  typedef enum logic [6:0] {
    OP_HALT = 7'd0,
    OP_ADD  = 7'd1,
    OP_SUB  = 7'd2,
    OP_MOVE = 7'd3,
    OP_DUMP = 7'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_VALUE  = 2'd0,
    KIND_HALTED = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  // Classification of one instruction, from the decoder to the core.
  typedef struct packed {
    logic             err;
    logic             halt;
    logic             move;
    logic             addsub;
    logic             sub;
    logic             dump;
    logic [IDX_W-1:0] ia;
    logic [IDX_W-1:0] ib;
  } dec_t;

endpackage

@@ rtl/prme_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module prme_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/prme_decode.sv @@
// Instruction decoder: opcode check, register range checks, predicate.
module prme_decode
  import prme_pkg::*;
(
  input  logic       run_if_zero_i,
  input  logic [6:0] action_i,
  input  logic [7:0] first_operand_i,
  input  logic [7:0] second_operand_i,
  input  logic       zero_bit_i,
  output dec_t       dec_o
);

  logic       a_ok;
  logic       b_ok;
  logic       skip;
  logic [8:0] a_off;
  logic [8:0] b_off;

  assign a_ok  = ({1'b0, first_operand_i} >= REG_LO) && ({1'b0, first_operand_i} < REG_HI);
  assign b_ok  = ({1'b0, second_operand_i} >= REG_LO) && ({1'b0, second_operand_i} < REG_HI);
  assign skip  = run_if_zero_i && !zero_bit_i;
  assign a_off = {1'b0, first_operand_i} - REG_LO;
  assign b_off = {1'b0, second_operand_i} - REG_LO;

  always_comb begin
    dec_o        = '0;
    dec_o.ia     = a_off[IDX_W-1:0];
    dec_o.ib     = b_off[IDX_W-1:0];
    unique case (action_i)
      OP_HALT: dec_o.halt = !skip;
      OP_ADD, OP_SUB: begin
        dec_o.err    = !(a_ok && b_ok);
        dec_o.addsub = a_ok && b_ok && !skip;
        dec_o.sub    = (action_i == OP_SUB);
      end
      OP_MOVE: begin
        dec_o.err  = !a_ok;
        dec_o.move = a_ok && !skip;
      end
      OP_DUMP: dec_o.dump = !skip;
      default: dec_o.err  = 1'b1;
    endcase
  end

endmodule

@@ rtl/predicated_register_machine_exec_core.sv @@
// Top level of the predicated register machine execution core.
//
// The core runs one instruction per input item against a small register file of
// NUM_REGS 8-bit registers, numbered from FIRST_REG upward, plus a zero flag.
// The register file lives in two copies of a synchronous RAM (one per source
// operand), written together, so add and subtract read both operands in one
// access. Move-immediate, halt, error, skipped instructions and items that
// arrive after the core has stopped are handled at acceptance; add and subtract
// read their operands, then write back through the RAM write port from EXEC; a
// dump reads the registers one by one in DUMP, one RAM read per register. A
// produced result that is not taken downstream holds the core until it is
// taken. A new item is taken while the last result of the previous one still
// waits in the output register, provided that register is being emptied. After
// halt or an error the core still accepts items but drops them until reset.
// Reset clears a per-register valid bit, so unwritten registers read as zero;
// there is no clearing pass.
module predicated_register_machine_exec_core
  import prme_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata, from bit 0: action[6:0], first_operand[14:7], second_operand[22:15], zero pad.
  input  logic [23:0] s_axis_tdata,
  // tuser: run_if_zero.
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: value[7:0].
  output logic [7:0]  m_axis_tdata,
  // tuser: kind[1:0].
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DUMP
  } state_e;

  state_e           state_q;
  logic             stopped_q;
  logic             zero_q;
  logic [NUM_REGS-1:0] valid_q;
  logic             va_q;
  logic             vb_q;
  logic             sub_q;
  logic [IDX_W-1:0] wr_idx_q;
  logic [IDX_W-1:0] cnt_q;
  logic             out_valid_q;
  logic [1:0]       out_kind_q;
  logic [7:0]       out_value_q;
  logic             out_last_q;

  dec_t             dec;
  logic             accept;
  logic             out_free;
  logic             live;
  logic [IDX_W-1:0] addr_a;
  logic [IDX_W-1:0] addr_b;
  logic [7:0]       rdata_a;
  logic [7:0]       rdata_b;
  logic [7:0]       val_a;
  logic [7:0]       val_b;
  logic [7:0]       alu_res;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [7:0]       wdata;

  prme_decode u_decode (
    .run_if_zero_i    (s_axis_tuser),
    .action_i         (s_axis_tdata[6:0]),
    .first_operand_i  (s_axis_tdata[14:7]),
    .second_operand_i (s_axis_tdata[22:15]),
    .zero_bit_i       (zero_q),
    .dec_o            (dec)
  );

  // The output register can take a new result when empty or being drained.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign live          = accept && !stopped_q;

  // Bank A serves the destination operand and the dump sweep; bank B the source.
  // During a dump the address advances only when the current word is consumed,
  // so a stalled word is simply read again.
  always_comb begin
    addr_a = dec.dump ? '0 : dec.ia;
    addr_b = dec.ib;
    if (state_q == ST_DUMP) begin
      addr_a = out_free ? IDX_W'(cnt_q + 1'b1) : cnt_q;
    end
  end

  // Never-written registers read as zero.
  assign val_a   = va_q ? rdata_a : '0;
  assign val_b   = vb_q ? rdata_b : '0;
  assign alu_res = sub_q ? (val_a - val_b) : (val_a + val_b);

  // Move writes at acceptance; add and subtract write back in the following cycle, from EXEC.
  always_comb begin
    we    = 1'b0;
    waddr = dec.ia;
    wdata = s_axis_tdata[22:15];
    if (state_q == ST_EXEC) begin
      we    = 1'b1;
      waddr = wr_idx_q;
      wdata = alu_res;
    end else if (live && dec.move) begin
      we = 1'b1;
    end
  end

  prme_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_bank_a (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (addr_a),
    .rdata_o (rdata_a)
  );

  prme_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_bank_b (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (addr_b),
    .rdata_o (rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stopped_q   <= 1'b0;
      zero_q      <= 1'b0;
      valid_q     <= '0;
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      sub_q       <= 1'b0;
      wr_idx_q    <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_kind_q  <= KIND_VALUE;
      out_value_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // A word read in the same cycle as a write to its entry is never used,
      // so the valid bit sampled with the read address matches the RAM word.
      va_q <= valid_q[addr_a];
      vb_q <= valid_q[addr_b];
      if (we) begin
        valid_q[waddr] <= 1'b1;
      end
      if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (live) begin
            // A skipped valid instruction matches none of these and changes nothing.
            if (dec.err || dec.halt) begin
              stopped_q   <= 1'b1;
              out_valid_q <= 1'b1;
              out_kind_q  <= dec.err ? KIND_ERROR : KIND_HALTED;
              out_value_q <= '0;
              out_last_q  <= 1'b1;
            end else if (dec.move) begin
              zero_q <= (s_axis_tdata[22:15] == 8'd0);
            end else if (dec.addsub) begin
              sub_q    <= dec.sub;
              wr_idx_q <= dec.ia;
              state_q  <= ST_EXEC;
            end else if (dec.dump) begin
              cnt_q   <= '0;
              state_q <= ST_DUMP;
            end
          end
        end
        ST_EXEC: begin
          zero_q  <= (alu_res == 8'd0);
          state_q <= ST_IDLE;
        end
        ST_DUMP: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= KIND_VALUE;
            out_value_q <= val_a;
            out_last_q  <= (cnt_q == LAST_IDX);
            cnt_q       <= IDX_W'(cnt_q + 1'b1);
            if (cnt_q == LAST_IDX) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

@@ rtl/prme_checker.sv @@
// Port-level checker for the execution core, bound to the top level.
module prme_checker
  import prme_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Halt and error results carry a zero value and close their item.
  a_stop_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_VALUE) |-> m_axis_tlast && (m_axis_tdata == 8'd0))
    else $error("halt or error result malformed");

  // Nothing follows a delivered halt or error result.
  a_stop_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && (m_axis_tuser != KIND_VALUE) |=> !m_axis_tvalid)
    else $error("result after stop");

  // Input is only taken while the output register can make room.
  a_in_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
    else $error("input taken with blocked output");

endmodule

bind predicated_register_machine_exec_core prme_checker u_prme_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
